>>> hdl/xabl_pkg.sv
// ----------------------------------------------------------------------------
// xabl_pkg
// shared types and constants of the extended-attribute block layout checker
// ----------------------------------------------------------------------------
`default_nettype none

package xabl_pkg;

   // layout constants of the attribute block
   localparam int unsigned HEADER_BYTES    = 32;
   localparam int unsigned ENTRY_BYTES     = 16;
   localparam int unsigned MAX_BLOCK_BYTES = 65536;
   localparam int unsigned XA_ROUND        = 3;
   localparam int unsigned XA_SENTINEL     = 4;

   localparam logic [31:0] XA_MAGIC        = 32'hEA02_0000;

   // widths
   localparam int unsigned BS_W       = 17;  // block size and in-block positions
   localparam int unsigned POS_W      = 18;  // positions with headroom for adds
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned OFF_W      = 16;
   localparam int unsigned NAME_W     = 8;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 32;

   // register reset values
   localparam logic [BS_W-1:0]   BLOCK_SIZE_RESET     = BS_W'(4096);
   localparam logic [WORD_W-1:0] REFCOUNT_LIMIT_RESET = WORD_W'(1024);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REFCOUNT_LIMIT = CSR_IDX_W'(1);

   // item kinds
   localparam logic ITEM_HEADER = 1'b0;
   localparam logic ITEM_ENTRY  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_CONTINUE = 2'd0,
      STATUS_VALID    = 2'd1,
      STATUS_CORRUPT  = 2'd2,
      STATUS_NOBLOCK  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_WALK = 2'd1
   } phase_type;

   typedef struct packed {
      logic              req_type;
      logic [WORD_W-1:0] header_magic;
      logic [WORD_W-1:0] header_blocks;
      logic [WORD_W-1:0] header_refs;
      logic              end_marker;
      logic [NAME_W-1:0] name_bytes;
      logic [WORD_W-1:0] value_block;
      logic [WORD_W-1:0] val_bytes;
      logic [OFF_W-1:0]  val_pos;
   } req_payload_type;

   typedef struct packed {
      phase_type       phase;
      logic [BS_W-1:0] cursor;
      logic [BS_W-1:0] floor;
   } walk_state_type;

   typedef struct packed {
      status_type     status;
      walk_state_type next;
   } eval_result_type;

endpackage

`default_nettype wire

>>> hdl/xabl_if.sv
// ----------------------------------------------------------------------------
// xabl channel interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface xabl_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic [xabl_pkg::WORD_W-1:0]         header_magic;
   logic [xabl_pkg::WORD_W-1:0]         header_blocks;
   logic [xabl_pkg::WORD_W-1:0]         header_refs;
   logic                                end_marker;
   logic [xabl_pkg::NAME_W-1:0]         name_bytes;
   logic [xabl_pkg::WORD_W-1:0]         value_block;
   logic [xabl_pkg::WORD_W-1:0]         val_bytes;
   logic [xabl_pkg::OFF_W-1:0]          val_pos;

   modport source (
      output valid, req_type, header_magic, header_blocks, header_refs,
             end_marker, name_bytes, value_block, val_bytes, val_pos,
      input  ready
   );
   modport sink (
      input  valid, req_type, header_magic, header_blocks, header_refs,
             end_marker, name_bytes, value_block, val_bytes, val_pos,
      output ready
   );
endinterface

interface xabl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

interface xabl_csr_if;
   logic                              valid;
   logic                              ready;
   logic [xabl_pkg::CSR_IDX_W-1:0]    index;
   logic [xabl_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/xabl_csr.sv
// ----------------------------------------------------------------------------
// xabl_csr
// configuration registers with block size saturation
// ----------------------------------------------------------------------------
`default_nettype none

module xabl_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   xabl_csr_if.sink                              csr_ch,
   output logic [xabl_pkg::BS_W-1:0]             block_size_eff,
   output logic [xabl_pkg::WORD_W-1:0]           refcount_limit
);

   logic [xabl_pkg::BS_W-1:0]   block_size_ff;
   logic [xabl_pkg::WORD_W-1:0] refcount_limit_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff     <= xabl_pkg::BLOCK_SIZE_RESET;
         refcount_limit_ff <= xabl_pkg::REFCOUNT_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == xabl_pkg::CSR_BLOCK_SIZE) begin
            block_size_ff <= csr_ch.data[xabl_pkg::BS_W-1:0];
         end
         if (csr_ch.index == xabl_pkg::CSR_REFCOUNT_LIMIT) begin
            refcount_limit_ff <= csr_ch.data[xabl_pkg::WORD_W-1:0];
         end
      end
   end

   // oversized block sizes clamp to the largest block
   always_comb begin
      if (block_size_ff > xabl_pkg::BS_W'(xabl_pkg::MAX_BLOCK_BYTES)) begin
         block_size_eff = xabl_pkg::BS_W'(xabl_pkg::MAX_BLOCK_BYTES);
      end else begin
         block_size_eff = block_size_ff;
      end
   end

   assign refcount_limit = refcount_limit_ff;

endmodule

`default_nettype wire

>>> hdl/xabl_eval.sv
// ----------------------------------------------------------------------------
// xabl_eval
// header and entry checks for one item, next walk state and status
// ----------------------------------------------------------------------------
`default_nettype none

module xabl_eval (
   input  wire xabl_pkg::req_payload_type      item,
   input  wire xabl_pkg::walk_state_type       state,
   input  wire logic [xabl_pkg::BS_W-1:0]      block_size_eff,
   input  wire logic [xabl_pkg::WORD_W-1:0]    refcount_limit,
   output xabl_pkg::eval_result_type           result
);

   localparam int unsigned PW = xabl_pkg::POS_W;
   localparam int unsigned VW = xabl_pkg::WORD_W + 1;

   logic [PW-1:0]             bs;
   logic [PW-1:0]             cur;
   logic [PW-1:0]             flr;
   logic [PW-1:0]             cur_s;
   logic [PW-1:0]             cur_e;
   logic [PW-1:0]             name_pad;
   logic [PW-1:0]             nxt;
   logic [PW-1:0]             nxt_s;
   logic [PW-1:0]             voff;
   logic [PW-1:0]             new_floor;
   logic [VW-1:0]             val_pad;
   logic [xabl_pkg::BS_W-1:0] room;
   logic                      hdr_bad;

   always_comb begin
      bs       = PW'(block_size_eff);
      cur      = PW'(state.cursor);
      flr      = PW'(state.floor);
      cur_s    = cur + PW'(xabl_pkg::XA_SENTINEL);
      cur_e    = cur + PW'(xabl_pkg::ENTRY_BYTES);
      name_pad = (PW'(item.name_bytes) + PW'(xabl_pkg::ENTRY_BYTES)
                  + PW'(xabl_pkg::XA_ROUND)) & ~PW'(xabl_pkg::XA_ROUND);
      nxt      = cur + name_pad;
      nxt_s    = nxt + PW'(xabl_pkg::XA_SENTINEL);
      voff     = PW'(item.val_pos);
      // only meaningful once the offset is known to be inside the block
      room     = block_size_eff - xabl_pkg::BS_W'(item.val_pos);
      val_pad  = (VW'(item.val_bytes) + VW'(xabl_pkg::XA_ROUND))
                 & ~VW'(xabl_pkg::XA_ROUND);
      new_floor = (voff < flr) ? voff : flr;

      hdr_bad = (bs < PW'(xabl_pkg::HEADER_BYTES + xabl_pkg::XA_SENTINEL))
             || (item.header_magic != xabl_pkg::XA_MAGIC)
             || (item.header_blocks != xabl_pkg::WORD_W'(1))
             || (item.header_refs == '0)
             || (item.header_refs > refcount_limit);

      result.status = xabl_pkg::STATUS_CONTINUE;
      result.next   = state;

      if (item.req_type == xabl_pkg::ITEM_HEADER) begin
         result.next.phase = xabl_pkg::PHASE_IDLE;
         if (hdr_bad) begin
            result.status = xabl_pkg::STATUS_CORRUPT;
         end else begin
            result.next.phase  = xabl_pkg::PHASE_WALK;
            result.next.cursor = xabl_pkg::BS_W'(xabl_pkg::HEADER_BYTES);
            result.next.floor  = block_size_eff;
         end
      end else if (state.phase != xabl_pkg::PHASE_WALK) begin
         result.status = xabl_pkg::STATUS_NOBLOCK;
      end else begin
         result.next.phase = xabl_pkg::PHASE_IDLE;
         if (cur_s > bs) begin
            result.status = xabl_pkg::STATUS_CORRUPT;
         end else if (item.end_marker) begin
            // terminator: sentinel must fit before the value area
            result.status = (cur_s > flr) ? xabl_pkg::STATUS_CORRUPT
                                          : xabl_pkg::STATUS_VALID;
         end else if ((cur_e > bs) || (nxt > bs) || (nxt_s > flr)
                      || (item.value_block != '0)) begin
            result.status = xabl_pkg::STATUS_CORRUPT;
         end else if (item.val_bytes != '0) begin
            if ((item.val_pos[1:0] != 2'b00) || (voff > bs)
                || (val_pad > VW'(room)) || (nxt_s > new_floor)) begin
               result.status = xabl_pkg::STATUS_CORRUPT;
            end else begin
               result.next.phase  = xabl_pkg::PHASE_WALK;
               result.next.cursor = nxt[xabl_pkg::BS_W-1:0];
               result.next.floor  = new_floor[xabl_pkg::BS_W-1:0];
            end
         end else if (item.val_pos != '0) begin
            // empty value must sit at offset zero
            result.status = xabl_pkg::STATUS_CORRUPT;
         end else begin
            result.next.phase  = xabl_pkg::PHASE_WALK;
            result.next.cursor = nxt[xabl_pkg::BS_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/xattr_block_layout_checker_unit.sv
// ----------------------------------------------------------------------------
// xattr_block_layout_checker_unit
// layout checker for one extended-attribute block, header then entries
// ----------------------------------------------------------------------------
// a request waits in the input register, its status in the result register
// throughput: one item per cycle while responses are taken, set by the single
//   check stage between the two registers, which also updates the walk state
// reset: synchronous, clears both valid flags, puts the walk in idle with
//   cursor and floor at zero, block size to 4096 and refcount limit to 1024
`default_nettype none

module xattr_block_layout_checker_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   xabl_req_if.sink    req_ch,
   xabl_rsp_if.source  rsp_ch,
   xabl_csr_if.sink    csr_ch
);

   // input register
   logic                      in_valid_ff;
   logic                      in_valid_in;
   xabl_pkg::req_payload_type in_data_ff;
   xabl_pkg::req_payload_type in_data_in;

   // walk state, updated as each item leaves the check stage
   xabl_pkg::walk_state_type  state_ff;
   xabl_pkg::walk_state_type  state_in;

   // result register
   logic                      out_valid_ff;
   logic                      out_valid_in;
   xabl_pkg::status_type      out_status_ff;
   xabl_pkg::status_type      out_status_in;

   logic [xabl_pkg::BS_W-1:0]   block_size_eff;
   logic [xabl_pkg::WORD_W-1:0] refcount_limit;
   xabl_pkg::eval_result_type   eval_res;

   logic advance;   // check stage moves its item into the result register
   logic req_fire;

   xabl_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_ch         (csr_ch),
      .block_size_eff (block_size_eff),
      .refcount_limit (refcount_limit)
   );

   xabl_eval u_eval (
      .item           (in_data_ff),
      .state          (state_ff),
      .block_size_eff (block_size_eff),
      .refcount_limit (refcount_limit),
      .result         (eval_res)
   );

   // result register frees up when empty or its transfer completes
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_data_in.req_type      = req_ch.req_type;
      in_data_in.header_magic  = req_ch.header_magic;
      in_data_in.header_blocks = req_ch.header_blocks;
      in_data_in.header_refs   = req_ch.header_refs;
      in_data_in.end_marker    = req_ch.end_marker;
      in_data_in.name_bytes    = req_ch.name_bytes;
      in_data_in.value_block   = req_ch.value_block;
      in_data_in.val_bytes     = req_ch.val_bytes;
      in_data_in.val_pos       = req_ch.val_pos;

      in_valid_in = req_fire || (in_valid_ff && !advance);

      state_in      = advance ? eval_res.next : state_ff;
      out_status_in = advance ? eval_res.status : out_status_ff;
      out_valid_in  = advance || (out_valid_ff && !rsp_ch.ready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff.phase  <= xabl_pkg::PHASE_IDLE;
         state_ff.cursor <= '0;
         state_ff.floor  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= in_data_in;
      end
      out_status_ff <= out_status_in;
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.status = out_status_ff;

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// regression of the extended-attribute block layout checker: header and entry
// items go in on the request channel, each status that comes back is checked
// against a walk predictor kept in step with every accepted transfer
// ----------------------------------------------------------------------------

module tb;

   // layout of the attribute block as the predictor sees it
   localparam longint unsigned HDR_SIZE       = 32;
   localparam longint unsigned ENTRY_LEN      = 16;
   localparam longint unsigned BLOCK_CAP      = 65536;
   localparam longint unsigned END_WORD_BYTES = 4;
   localparam longint unsigned ROUND_MASK     = 3;
   localparam logic [31:0]     ATTR_MAGIC     = 32'hEA02_0000;

   localparam int HALF_PERIOD = 5;
   localparam int SETTLE_CYCLES = 4;        // pipeline is 2 deep, leave margin
   localparam longint TIMEOUT_NS = 5000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xabl_req_if req_ch ();
   xabl_rsp_if rsp_ch ();
   xabl_csr_if csr_ch ();

   xattr_block_layout_checker_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #HALF_PERIOD clock = ~clock;

   // register shadow, follows every accepted register write
   logic [xabl_pkg::BS_W-1:0]   cfg_block_size = 17'd4096;
   logic [xabl_pkg::WORD_W-1:0] cfg_ref_limit  = 32'd1024;

   // walk predictor state, updated at each accepted request transfer
   longint unsigned     walk_cursor = 0;
   longint unsigned     walk_floor  = 0;
   xabl_pkg::phase_type walk_phase  = xabl_pkg::PHASE_IDLE;

   // statuses still owed by the block, oldest first
   xabl_pkg::status_type pending_status[$];

   int          fail_count = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   bit          sender_gaps_on = 1'b1;
   bit          sink_stalls_on = 1'b1;
   int unsigned sink_run = 0;

   // -------------------------------------------------------------------------
   // predictor: status of one item, walk state moves as the block's does
   // -------------------------------------------------------------------------
   function automatic xabl_pkg::status_type layout_verdict(
      input xabl_pkg::req_payload_type it);
      longint unsigned bs;
      longint unsigned nxt;
      longint unsigned padded;
      longint unsigned flr;
      longint unsigned voff;
      // oversized block size saturates at the largest block
      bs = (cfg_block_size > BLOCK_CAP) ? BLOCK_CAP : cfg_block_size;

      if (it.req_type == xabl_pkg::ITEM_HEADER) begin
         // a header always closes any open walk, and a good one opens a fresh walk
         walk_phase = xabl_pkg::PHASE_IDLE;
         if (bs < HDR_SIZE + END_WORD_BYTES)
            return xabl_pkg::STATUS_CORRUPT;
         if (it.header_magic != ATTR_MAGIC || it.header_blocks != 32'd1)
            return xabl_pkg::STATUS_CORRUPT;
         if (it.header_refs == 32'd0 || it.header_refs > cfg_ref_limit)
            return xabl_pkg::STATUS_CORRUPT;
         walk_cursor = HDR_SIZE;
         walk_floor  = bs;
         walk_phase  = xabl_pkg::PHASE_WALK;
         return xabl_pkg::STATUS_CONTINUE;
      end

      // entry with no block open leaves everything as it was
      if (walk_phase != xabl_pkg::PHASE_WALK)
         return xabl_pkg::STATUS_NOBLOCK;
      walk_phase = xabl_pkg::PHASE_IDLE;

      if (walk_cursor + END_WORD_BYTES > bs)
         return xabl_pkg::STATUS_CORRUPT;
      if (it.end_marker) begin
         if (walk_cursor + END_WORD_BYTES > walk_floor)
            return xabl_pkg::STATUS_CORRUPT;
         return xabl_pkg::STATUS_VALID;
      end

      if (walk_cursor + ENTRY_LEN > bs)
         return xabl_pkg::STATUS_CORRUPT;
      nxt = walk_cursor + ((it.name_bytes + ENTRY_LEN + ROUND_MASK) & ~ROUND_MASK);
      if (nxt > bs || nxt + END_WORD_BYTES > walk_floor)
         return xabl_pkg::STATUS_CORRUPT;
      if (it.value_block != 0)
         return xabl_pkg::STATUS_CORRUPT;

      flr  = walk_floor;
      voff = it.val_pos;
      if (it.val_bytes != 0) begin
         padded = (it.val_bytes + ROUND_MASK) & ~ROUND_MASK;
         if ((voff & ROUND_MASK) != 0 || voff > bs || padded > bs - voff)
            return xabl_pkg::STATUS_CORRUPT;
         if (voff < flr)
            flr = voff;
         if (nxt + END_WORD_BYTES > flr)
            return xabl_pkg::STATUS_CORRUPT;
      end else if (voff != 0) begin
         // empty value must sit at offset zero
         return xabl_pkg::STATUS_CORRUPT;
      end

      walk_cursor = nxt;
      walk_floor  = flr;
      walk_phase  = xabl_pkg::PHASE_WALK;
      return xabl_pkg::STATUS_CONTINUE;
   endfunction

   // -------------------------------------------------------------------------
   // item builders, fields the item kind ignores carry random junk
   // -------------------------------------------------------------------------
   function automatic xabl_pkg::req_payload_type make_header(
      input logic [31:0] magic,
      input logic [31:0] blocks,
      input logic [31:0] refs);
      xabl_pkg::req_payload_type it;
      it.req_type      = xabl_pkg::ITEM_HEADER;
      it.header_magic  = magic;
      it.header_blocks = blocks;
      it.header_refs   = refs;
      it.end_marker    = 1'($urandom);
      it.name_bytes    = 8'($urandom);
      it.value_block   = $urandom;
      it.val_bytes     = $urandom;
      it.val_pos       = 16'($urandom);
      return it;
   endfunction

   function automatic xabl_pkg::req_payload_type make_entry(
      input logic        term,
      input logic [7:0]  name_len,
      input logic [31:0] vblock,
      input logic [31:0] vsize,
      input logic [15:0] voff);
      xabl_pkg::req_payload_type it;
      it.req_type      = xabl_pkg::ITEM_ENTRY;
      it.header_magic  = $urandom;
      it.header_blocks = $urandom;
      it.header_refs   = $urandom;
      it.end_marker    = term;
      it.name_bytes    = name_len;
      it.value_block   = vblock;
      it.val_bytes     = vsize;
      it.val_pos       = voff;
      return it;
   endfunction

   function automatic xabl_pkg::req_payload_type good_header();
      return make_header(ATTR_MAGIC, 32'd1, $urandom_range(1, cfg_ref_limit));
   endfunction

   function automatic xabl_pkg::req_payload_type terminator_item();
      return make_entry(1'b1, 8'($urandom), $urandom, $urandom, 16'($urandom));
   endfunction

   // fully random transfer: mostly corrupt headers and entries with no block open
   function automatic xabl_pkg::req_payload_type noise_item();
      xabl_pkg::req_payload_type it;
      it = make_header($urandom, $urandom, $urandom);
      it.req_type = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // header with one field changed, mostly to a value the block rejects
   function automatic xabl_pkg::req_payload_type broken_header();
      xabl_pkg::req_payload_type it;
      it = good_header();
      case ($urandom_range(0, 3))
         0: it.header_magic = ATTR_MAGIC ^ (32'd1 << $urandom_range(0, 31));
         1: it.header_blocks = ($urandom_range(0, 1) != 0) ? 32'd0
                               : $urandom_range(2, 32'hFFFF_FFFF);
         2: it.header_refs = 32'd0;
         default: it.header_refs = ($urandom_range(0, 1) != 0) ? cfg_ref_limit + 32'd1
                                   : $urandom;
      endcase
      return it;
   endfunction

   // entry laid out for the current walk, with an occasional defect or collision
   function automatic xabl_pkg::req_payload_type random_entry();
      longint unsigned nxt;
      longint unsigned vsize;
      longint unsigned padded;
      longint unsigned voff;
      int unsigned     name_len;
      xabl_pkg::req_payload_type it;
      name_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                 : $urandom_range(0, 24);
      nxt = walk_cursor + ((name_len + ENTRY_LEN + ROUND_MASK) & ~ROUND_MASK);
      if ($urandom_range(0, 7) == 0)
         vsize = 0;
      else if ($urandom_range(0, 9) == 0)
         vsize = $urandom_range(1, 4096);
      else
         vsize = $urandom_range(1, 48);
      padded = (vsize + ROUND_MASK) & ~ROUND_MASK;
      // value goes just under the lowest value so far, aligned down
      if (vsize == 0 || walk_floor < padded)
         voff = 0;
      else
         voff = (walk_floor - padded) & ~ROUND_MASK;
      it = make_entry(1'b0, 8'(name_len), 32'd0, 32'(vsize), 16'(voff));
      if (nxt + END_WORD_BYTES > voff && vsize != 0)
         it.end_marker = 1'b0; // will collide, the block should flag it
      case ($urandom_range(0, 19))
         0: it.value_block = $urandom_range(1, 32'hFFFF_FFFF);
         1: it.val_pos[1:0] = 2'($urandom_range(1, 3));
         2: it.val_bytes = $urandom;
         3: it.val_pos = 16'($urandom);
         4: it.name_bytes = 8'hFF;
         5: begin
            it.val_bytes = 32'd0;
            it.val_pos   = 16'($urandom_range(1, 65535));
         end
         default: ;
      endcase
      return it;
   endfunction

   // -------------------------------------------------------------------------
   // request side: bursts of back-to-back transfers with random gaps
   // -------------------------------------------------------------------------
   task automatic send_item(input xabl_pkg::req_payload_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= it.req_type;
      req_ch.header_magic  <= it.header_magic;
      req_ch.header_blocks <= it.header_blocks;
      req_ch.header_refs   <= it.header_refs;
      req_ch.end_marker    <= it.end_marker;
      req_ch.name_bytes    <= it.name_bytes;
      req_ch.value_block   <= it.value_block;
      req_ch.val_bytes     <= it.val_bytes;
      req_ch.val_pos       <= it.val_pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // transfer taken at this edge, predict with the state before it
      pending_status.push_back(layout_verdict(it));
      items_sent++;
   endtask

   // hold off requests until every owed status has come back
   task automatic wait_all_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [xabl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == xabl_pkg::CSR_BLOCK_SIZE)
         cfg_block_size = value[xabl_pkg::BS_W-1:0];
      else if (idx == xabl_pkg::CSR_REFCOUNT_LIMIT)
         cfg_ref_limit = value;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] bs, input logic [31:0] lim);
      wait_all_results();
      write_reg(xabl_pkg::CSR_BLOCK_SIZE, bs);
      write_reg(xabl_pkg::CSR_REFCOUNT_LIMIT, lim);
   endtask

   // -------------------------------------------------------------------------
   // response side: ready runs high and low on its own pattern
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_run = 0;
      end else if (sink_run != 0) begin
         sink_run--;
      end else if (sink_stalls_on && rsp_ch.ready) begin
         rsp_ch.ready <= 1'b0;
         sink_run = $urandom_range(0, 4);
      end else begin
         rsp_ch.ready <= 1'b1;
         // now and then a long run with no stall at all
         sink_run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                    : $urandom_range(0, 12);
      end
   end

   // every response transfer is matched against the oldest owed status
   always @(posedge clock) begin
      xabl_pkg::status_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_status.size() == 0) begin
            $error("status: no result pending, actual %0d", rsp_ch.status);
            fail_count++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_ch.status !== want) begin
               $error("status mismatch: expected %0d actual %0d", want, rsp_ch.status);
               fail_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------

   // header field checks, restart while walking, entries with no block open
   task automatic test_header_checks();
      send_item(make_entry(1'b0, 8'd0, 32'd0, 32'd0, 16'd0));
      send_item(make_header(~ATTR_MAGIC, 32'd1, 32'd1));
      send_item(make_header(ATTR_MAGIC, 32'd0, 32'd1));
      send_item(make_header(ATTR_MAGIC, 32'hFFFF_FFFF, 32'd1));
      send_item(make_header(ATTR_MAGIC, 32'd1, 32'd0));
      send_item(make_header(ATTR_MAGIC, 32'd1, 32'd1025));
      send_item(make_header(ATTR_MAGIC, 32'd1, 32'd1024));
      send_item(make_header(ATTR_MAGIC, 32'd1, 32'd1));
      send_item(terminator_item());
      send_item(terminator_item());
   endtask

   // value block, alignment, empty value, oversize and overlap checks on entries with the reset block size
   task automatic test_entry_checks();
      send_item(good_header());
      send_item(make_entry(1'b0, 8'hFF, 32'd0, 32'd0, 16'd0));
      send_item(make_entry(1'b0, 8'd0, 32'd0, 32'd4, 16'd4092));
      send_item(make_entry(1'b0, 8'd0, 32'hFFFF_FFFF, 32'd0, 16'd0));
      // misaligned value offset
      send_item(good_header());
      send_item(make_entry(1'b0, 8'd4, 32'd0, 32'd8, 16'd4090));
      // empty value at a nonzero offset
      send_item(good_header());
      send_item(make_entry(1'b0, 8'd0, 32'd0, 32'd0, 16'hFFFF));
      // value larger than the block
      send_item(good_header());
      send_item(make_entry(1'b0, 8'd0, 32'd0, 32'hFFFF_FFFF, 16'd0));
      // value reaches back into the entry area
      send_item(good_header());
      send_item(make_entry(1'b0, 8'd0, 32'd0, 32'd4, 16'd40));
      send_item(good_header());
      send_item(terminator_item());
   endtask

   // smallest, zero, saturated block sizes and refcount limit extremes
   task automatic test_config_extremes();
      set_config(32'd36, 32'd1024);
      send_item(good_header());
      send_item(terminator_item());
      send_item(good_header());
      send_item(make_entry(1'b0, 8'd0, 32'd0, 32'd0, 16'd0));
      set_config(32'd0, 32'd1024);
      send_item(good_header());
      // top of the 17-bit register, treated as the largest block
      set_config(32'h0001_FFFF, 32'hFFFF_FFFF);
      send_item(make_header(ATTR_MAGIC, 32'd1, 32'hFFFF_FFFF));
      send_item(make_entry(1'b0, 8'd0, 32'd0, 32'd4, 16'd65532));
      send_item(terminator_item());
      set_config(32'd65536, 32'd1);
      send_item(make_header(ATTR_MAGIC, 32'd1, 32'd2));
   endtask

   // block size shrinks between two entries of an open walk
   task automatic test_block_size_mid_walk();
      set_config(32'd4096, 32'd1024);
      send_item(good_header());
      send_item(make_entry(1'b0, 8'd0, 32'd0, 32'd0, 16'd0));
      wait_all_results();
      write_reg(xabl_pkg::CSR_BLOCK_SIZE, 32'd48);
      send_item(terminator_item());
   endtask

   // mostly well-formed walks with random content, some noise and defects
   task automatic run_random_phase(input int unsigned n_items, input logic [31:0] bs,
                                   input logic [31:0] lim, input bit gaps,
                                   input bit stalls);
      int unsigned target;
      int unsigned n_entries;
      int unsigned k;
      target = items_sent + n_items;
      set_config(bs, lim);
      sender_gaps_on = gaps;
      sink_stalls_on = stalls;
      while (items_sent < target) begin
         // sender sometimes waits for the block to run dry
         if ($urandom_range(0, 49) == 0)
            wait_all_results();
         if ($urandom_range(0, 11) == 0) begin
            send_item(noise_item());
         end else begin
            if ($urandom_range(0, 7) == 0)
               send_item(broken_header());
            else
               send_item(good_header());
            n_entries = $urandom_range(0, 10);
            for (k = 0; k < n_entries && walk_phase == xabl_pkg::PHASE_WALK; k++)
               send_item(random_entry());
            // a few walks stay open and get cut by the next header
            if (walk_phase == xabl_pkg::PHASE_WALK && $urandom_range(0, 9) != 0)
               send_item(terminator_item());
         end
      end
   endtask

   task automatic test_random_walks();
      run_random_phase(110, 32'd4096, 32'd1024, 1'b1, 1'b1);
      run_random_phase(110, 32'd160, 32'hFFFF_FFFF, 1'b1, 1'b1);
      run_random_phase(90, 32'd65536, 32'd1, 1'b0, 1'b0);
      run_random_phase(110, $urandom_range(36, 1024), $urandom_range(1, 4096), 1'b1, 1'b1);
   endtask

   // -------------------------------------------------------------------------
   // sequence
   // -------------------------------------------------------------------------
   initial begin
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= xabl_pkg::ITEM_HEADER;
      req_ch.header_magic  <= '0;
      req_ch.header_blocks <= '0;
      req_ch.header_refs   <= '0;
      req_ch.end_marker    <= 1'b0;
      req_ch.name_bytes    <= '0;
      req_ch.value_block   <= '0;
      req_ch.val_bytes     <= '0;
      req_ch.val_pos       <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= xabl_pkg::CSR_BLOCK_SIZE;
      csr_ch.data          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_header_checks();
      test_entry_checks();
      test_config_extremes();
      test_block_size_mid_walk();
      test_random_walks();

      wait_all_results();
      if (fail_count == 0) begin
         $display("xattr_block_layout_checker_unit regression: pass");
      end else begin
         $display("xattr_block_layout_checker_unit regression: fail");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("xattr_block_layout_checker_unit regression: fail");
      $finish;
   end

endmodule

>>> sim.f
hdl/xabl_pkg.sv
hdl/xabl_if.sv
hdl/xabl_csr.sv
hdl/xabl_eval.sv
hdl/xattr_block_layout_checker_unit.sv
verif/tb.sv
